### design/sis_pkg.sv
`default_nettype none

package sis_pkg;

   localparam int BUCKETS = 4096;
   localparam int CELLS = 8;
   localparam int TAIL_CAP = 100000;
   localparam logic [19:0] PERS_MAX = 20'hFFFFF;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
   localparam logic [2:0] REG_PERSIST_WEIGHT = 3'd1;
   localparam logic [2:0] REG_FREQ_WEIGHT = 3'd2;
   localparam logic [2:0] REG_FREQ_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_PERSIST_THRESHOLD = 3'd4;
   localparam logic [2:0] REG_FREQ_ONLY_DECAY = 3'd5;
   localparam logic [2:0] REG_BUCKETS_IN_USE = 3'd6;

   typedef struct packed {
      logic [63:0] key;
      logic [11:0] bucket;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic       significant;
      logic       replaced;
      logic [2:0] cell_index;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic        valid;
      logic [19:0] persistency;
      logic [31:0] count;
      logic        odd_flag;
      logic        even_flag;
   } cell_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_LAST,
      ST_DIV_TIME,
      ST_PLAN,
      ST_FULL_RD,
      ST_FULL_WR,
      ST_MUL_POS,
      ST_MUL_LIM,
      ST_PART_RD,
      ST_PART_WR,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_PROBE_CMP,
      ST_DECAY,
      ST_MIN_RD,
      ST_MIN_CHK,
      ST_WRITE
   } state_type;

   // fold the flag of the finished half period into persistency
   function automatic cell_type fold_cell(input cell_type c, input logic parity);
      cell_type r;
      r = c;
      if (parity && c.even_flag) begin
         if (c.persistency < PERS_MAX) r.persistency = c.persistency + 20'd1;
         r.even_flag = 1'b0;
      end
      if (!parity && c.odd_flag) begin
         if (c.persistency < PERS_MAX) r.persistency = c.persistency + 20'd1;
         r.odd_flag = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/sis_ram.sv
`default_nettype none

module sis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/significant_item_sketch_top.sv
// sequence: two serial divisions by the window length, then a read and a write per swept cell,
// a read, a check and a compare per probed cell (fewer cells on a hit), and a further read and
// check per cell on a replacement; the clock sweep and the bucket probe share one cell memory
// with one read and one write port, one cell per access
// throughput: one transaction at a time, the next one taken the cycle after the result loads
// reset: a clearing pass writes all BUCKETS*CELLS cells with req_ready low; configuration
// writes are taken throughout
`default_nettype none

module significant_item_sketch_top #(
   parameter int BUCKETS = sis_pkg::BUCKETS,
   parameter int CELLS = sis_pkg::CELLS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire sis_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output sis_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [sis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sis_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NCELL = BUCKETS * CELLS;
   localparam int ADDR_W = $clog2(NCELL);
   localparam int POS_W = $clog2(NCELL + 1);
   localparam int CELL_W = $clog2(CELLS);
   localparam int ACC_W = 32 + POS_W;
   localparam int LIM_W = 33 + POS_W;
   localparam int CW = $bits(sis_pkg::cell_type);
   // bucket wrap by reciprocal multiplication, exact for any 12-bit index
   localparam int BKT_SH = 12 + $clog2(BUCKETS);
   localparam longint BKT_RECIP =
      ((longint'(1) <<< BKT_SH) + longint'(BUCKETS) - 1) / longint'(BUCKETS);

   // configuration
   logic [31:0]        wl_cfg_ff;
   logic signed [7:0]  pw_ff;
   logic signed [7:0]  fw_ff;
   logic [31:0]        fthr_ff;
   logic [19:0]        pthr_ff;
   logic               fod_ff;
   logic [12:0]        nbu_ff;

   sis_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0]   clr_ff, clr_in;
   sis_pkg::req_type   req_ff, req_in;
   logic [POS_W-1:0]   total_ff, total_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic [31:0]        div_num_ff, div_num_in;
   logic [31:0]        div_rem_ff, div_rem_in;
   logic [31:0]        div_quo_ff, div_quo_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic [31:0]        lp_ff, lp_in;
   logic [31:0]        tp_ff, tp_in;
   logic [31:0]        phase_ff, phase_in;
   logic [11:0]        bkt_ff, bkt_in;
   logic               parity_ff, parity_in;
   logic [1:0]         sweeps_ff, sweeps_in;
   logic               flip_ff, flip_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [LIM_W-1:0]   lim_ff, lim_in;
   logic [POS_W-1:0]   base_ff, base_in;
   logic [CELL_W-1:0]  k_ff, k_in;
   sis_pkg::cell_type  cur_ff, cur_in;
   logic signed [29:0] prod_p_ff, prod_p_in;
   logic signed [40:0] prod_c_ff, prod_c_in;
   logic signed [41:0] best_v_ff, best_v_in;
   logic [CELL_W-1:0]  best_k_ff, best_k_in;
   sis_pkg::cell_type  best_cell_ff, best_cell_in;
   logic [19:0]        mp_ff, mp_in;
   logic [31:0]        mc_ff, mc_in;
   sis_pkg::cell_type  wr_cell_ff, wr_cell_in;
   logic [CELL_W-1:0]  wr_k_ff, wr_k_in;
   sis_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sis_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // memory port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CW-1:0]      ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CW-1:0]      ram_rdata;
   sis_pkg::cell_type  rd_cell;

   // derived values
   logic [31:0]        wl;
   logic [12:0]        nb_raw;
   logic [16:0]        nb_wide;
   logic [POS_W-1:0]   total_calc;
   logic               accept;
   logic               out_free;
   logic               full_more;
   logic               part_more;
   logic               div_end;
   logic               last_k;
   logic [41:0]        bkt_prod;
   logic [11:0]        bkt_quo;
   logic [11:0]        bkt_mod;
   logic [POS_W-1:0]   probe_addr;
   logic [POS_W-1:0]   wr_addr_full;

   // shared divider step
   logic [32:0]        div_den;
   logic [32:0]        div_sh;
   logic               div_ge;
   logic [32:0]        div_rem_nx;
   logic [31:0]        div_quo_nx;

   // shared sweep multiplier
   logic [32:0]        mul_a;
   logic [POS_W-1:0]   mul_b;
   logic [LIM_W-1:0]   mul_p;

   // cell update logic
   logic               key_match;
   sis_pkg::cell_type  hit_cell;
   logic               hit_sig;
   logic [20:0]        p21;
   logic signed [41:0] score;
   sis_pkg::cell_type  dec_cell;
   logic               dec_repl;
   logic [19:0]        mp_nx;
   logic [31:0]        mc_nx;
   sis_pkg::cell_type  new_cell;
   logic [31:0]        periods;
   logic [1:0]         sweeps_calc;
   logic [CELL_W+2:0]  best_idx_ext;
   logic [CELL_W+2:0]  k_idx_ext;

   sis_ram #(
      .WIDTH(CW),
      .DEPTH(NCELL)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_cell = sis_pkg::cell_type'(ram_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_cfg_ff <= 32'd1000;
         pw_ff <= 8'sd3;
         fw_ff <= 8'sd10;
         fthr_ff <= 32'd100;
         pthr_ff <= 20'd30;
         fod_ff <= 1'b1;
         nbu_ff <= 13'd4096;
      end else if (csr_we) begin
         case (csr_index)
            sis_pkg::REG_WINDOW_LENGTH: begin
               wl_cfg_ff <= csr_wdata;
            end
            sis_pkg::REG_PERSIST_WEIGHT: begin
               pw_ff <= $signed(csr_wdata[7:0]);
            end
            sis_pkg::REG_FREQ_WEIGHT: begin
               fw_ff <= $signed(csr_wdata[7:0]);
            end
            sis_pkg::REG_FREQ_THRESHOLD: begin
               fthr_ff <= csr_wdata;
            end
            sis_pkg::REG_PERSIST_THRESHOLD: begin
               pthr_ff <= csr_wdata[19:0];
            end
            sis_pkg::REG_FREQ_ONLY_DECAY: begin
               fod_ff <= csr_wdata[0];
            end
            sis_pkg::REG_BUCKETS_IN_USE: begin
               nbu_ff <= csr_wdata[12:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      wl = (wl_cfg_ff == 32'd0) ? 32'd1 : wl_cfg_ff;
      nb_raw = (nbu_ff == 13'd0) ? 13'd1 : nbu_ff;
      nb_wide = {4'b0, nb_raw};
      if (nb_wide > 17'(BUCKETS)) nb_wide = 17'(BUCKETS);
      total_calc = POS_W'(32'(nb_wide) * 32'(CELLS));
      accept = req_valid && req_ready;
      out_free = !rsp_valid_ff || rsp_ready;
      full_more = pos_ff < total_ff;
      part_more = full_more && ({1'b0, acc_ff} < lim_ff);
      div_end = div_cnt_ff == 5'd31;
      last_k = k_ff == CELL_W'(CELLS - 1);
      bkt_prod = 42'(req_ff.bucket) * 42'(BKT_RECIP);
      bkt_quo = 12'(bkt_prod >> BKT_SH);
      bkt_mod = 12'(32'(req_ff.bucket) - 32'(bkt_quo) * 32'(BUCKETS));
      probe_addr = base_ff + POS_W'(k_ff);
      wr_addr_full = base_ff + POS_W'(wr_k_ff);

      div_den = {1'b0, wl};
      div_sh = {div_rem_ff, div_num_ff[31]};
      div_ge = div_sh >= div_den;
      div_rem_nx = div_ge ? (div_sh - div_den) : div_sh;
      div_quo_nx = {div_quo_ff[30:0], div_ge};

      if (state_ff == sis_pkg::ST_MUL_LIM) begin
         mul_a = {1'b0, phase_ff} + 33'd1;
         mul_b = total_ff;
      end else begin
         mul_a = {1'b0, wl};
         mul_b = pos_ff;
      end
      mul_p = LIM_W'(mul_a * mul_b);

      key_match = rd_cell.valid && (rd_cell.key == req_ff.key);
      hit_cell = rd_cell;
      if (parity_ff) hit_cell.odd_flag = 1'b1;
      else hit_cell.even_flag = 1'b1;
      if (rd_cell.count != 32'hFFFF_FFFF) hit_cell.count = rd_cell.count + 32'd1;
      hit_sig = (hit_cell.count >= fthr_ff) &&
                (({1'b0, rd_cell.persistency} + 21'd1) >= {1'b0, pthr_ff});

      p21 = {1'b0, rd_cell.persistency} + 21'(rd_cell.odd_flag) + 21'(rd_cell.even_flag);
      score = 42'(prod_p_ff) + 42'(prod_c_ff);

      dec_cell = best_cell_ff;
      if (!fod_ff && best_cell_ff.persistency != 20'd0) begin
         dec_cell.persistency = best_cell_ff.persistency - 20'd1;
      end
      if (best_cell_ff.count != 32'd0) dec_cell.count = best_cell_ff.count - 32'd1;
      dec_repl = (dec_cell.count == 32'd0) || (fw_ff <= 8'sd0);

      mp_nx = mp_ff;
      mc_nx = mc_ff;
      if (k_ff != best_k_ff) begin
         if (rd_cell.persistency < mp_ff) mp_nx = rd_cell.persistency;
         if (rd_cell.count < mc_ff) mc_nx = rd_cell.count;
      end
      new_cell.key = req_ff.key;
      new_cell.valid = 1'b1;
      new_cell.persistency = (mp_nx != 20'd0) ? (mp_nx - 20'd1) : 20'd0;
      new_cell.count = (mc_nx > 32'd2) ? (mc_nx - 32'd1) : 32'd1;
      new_cell.odd_flag = parity_ff;
      new_cell.even_flag = !parity_ff;

      periods = tp_ff - lp_ff;
      sweeps_calc = (periods < 32'd3) ? periods[1:0] : 2'd3;
      best_idx_ext = {3'b0, best_k_ff};
      k_idx_ext = {3'b0, k_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sis_pkg::ST_CLEAR: begin
            if (clr_ff == POS_W'(NCELL - 1)) state_in = sis_pkg::ST_IDLE;
         end
         sis_pkg::ST_IDLE: begin
            if (accept) state_in = sis_pkg::ST_DIV_LAST;
         end
         sis_pkg::ST_DIV_LAST: begin
            if (div_end) state_in = sis_pkg::ST_DIV_TIME;
         end
         sis_pkg::ST_DIV_TIME: begin
            if (div_end) state_in = sis_pkg::ST_PLAN;
         end
         sis_pkg::ST_PLAN: begin
            state_in = (tp_ff > lp_ff) ? sis_pkg::ST_FULL_RD : sis_pkg::ST_MUL_POS;
         end
         sis_pkg::ST_FULL_RD: begin
            if (full_more) state_in = sis_pkg::ST_FULL_WR;
            else if (sweeps_ff == 2'd1) state_in = sis_pkg::ST_MUL_POS;
         end
         sis_pkg::ST_FULL_WR: begin
            state_in = sis_pkg::ST_FULL_RD;
         end
         sis_pkg::ST_MUL_POS: begin
            state_in = sis_pkg::ST_MUL_LIM;
         end
         sis_pkg::ST_MUL_LIM: begin
            state_in = sis_pkg::ST_PART_RD;
         end
         sis_pkg::ST_PART_RD: begin
            state_in = part_more ? sis_pkg::ST_PART_WR : sis_pkg::ST_PROBE_RD;
         end
         sis_pkg::ST_PART_WR: begin
            state_in = sis_pkg::ST_PART_RD;
         end
         sis_pkg::ST_PROBE_RD: begin
            state_in = sis_pkg::ST_PROBE_CHK;
         end
         sis_pkg::ST_PROBE_CHK: begin
            state_in = key_match ? sis_pkg::ST_WRITE : sis_pkg::ST_PROBE_CMP;
         end
         sis_pkg::ST_PROBE_CMP: begin
            state_in = last_k ? sis_pkg::ST_DECAY : sis_pkg::ST_PROBE_RD;
         end
         sis_pkg::ST_DECAY: begin
            state_in = dec_repl ? sis_pkg::ST_MIN_RD : sis_pkg::ST_WRITE;
         end
         sis_pkg::ST_MIN_RD: begin
            state_in = sis_pkg::ST_MIN_CHK;
         end
         sis_pkg::ST_MIN_CHK: begin
            state_in = last_k ? sis_pkg::ST_WRITE : sis_pkg::ST_MIN_RD;
         end
         sis_pkg::ST_WRITE: begin
            if (out_free) state_in = sis_pkg::ST_IDLE;
         end
         default: begin
            state_in = sis_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = pos_ff[ADDR_W-1:0];
      ram_wdata = CW'(sis_pkg::fold_cell(rd_cell, parity_ff));
      ram_re = 1'b0;
      ram_raddr = pos_ff[ADDR_W-1:0];
      case (state_ff)
         sis_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff[ADDR_W-1:0];
            ram_wdata = '0;
         end
         sis_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sis_pkg::ST_FULL_RD: begin
            ram_re = full_more;
         end
         sis_pkg::ST_PART_RD: begin
            ram_re = part_more;
         end
         sis_pkg::ST_FULL_WR, sis_pkg::ST_PART_WR: begin
            ram_we = 1'b1;
         end
         sis_pkg::ST_PROBE_RD, sis_pkg::ST_MIN_RD: begin
            ram_re = 1'b1;
            ram_raddr = probe_addr[ADDR_W-1:0];
         end
         sis_pkg::ST_WRITE: begin
            ram_we = out_free;
            ram_waddr = wr_addr_full[ADDR_W-1:0];
            ram_wdata = CW'(wr_cell_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in = clr_ff;
      req_in = req_ff;
      total_in = total_ff;
      pos_in = pos_ff;
      last_time_in = last_time_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      lp_in = lp_ff;
      tp_in = tp_ff;
      phase_in = phase_ff;
      bkt_in = bkt_ff;
      parity_in = parity_ff;
      sweeps_in = sweeps_ff;
      flip_in = flip_ff;
      acc_in = acc_ff;
      lim_in = lim_ff;
      base_in = base_ff;
      k_in = k_ff;
      cur_in = cur_ff;
      prod_p_in = prod_p_ff;
      prod_c_in = prod_c_ff;
      best_v_in = best_v_ff;
      best_k_in = best_k_ff;
      best_cell_in = best_cell_ff;
      mp_in = mp_ff;
      mc_in = mc_ff;
      wr_cell_in = wr_cell_ff;
      wr_k_in = wr_k_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         sis_pkg::ST_CLEAR: begin
            clr_in = clr_ff + POS_W'(1);
         end
         sis_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               total_in = total_calc;
               if (pos_ff >= total_calc) pos_in = '0;
               div_num_in = last_time_ff;
               div_rem_in = '0;
               div_quo_in = '0;
               div_cnt_in = '0;
            end
         end
         sis_pkg::ST_DIV_LAST, sis_pkg::ST_DIV_TIME: begin
            div_num_in = {div_num_ff[30:0], 1'b0};
            div_rem_in = div_rem_nx[31:0];
            div_quo_in = div_quo_nx;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_end) begin
               div_rem_in = '0;
               div_quo_in = '0;
               if (state_ff == sis_pkg::ST_DIV_LAST) begin
                  lp_in = div_quo_nx;
                  div_num_in = req_ff.timestamp;
               end else begin
                  tp_in = div_quo_nx;
                  phase_in = div_rem_nx[31:0];
                  bkt_in = bkt_mod;
               end
            end
         end
         sis_pkg::ST_PLAN: begin
            parity_in = lp_ff[0];
            base_in = POS_W'(32'(bkt_ff) * 32'(CELLS));
            if (tp_ff > lp_ff) begin
               sweeps_in = sweeps_calc;
               flip_in = periods[0] ^ sweeps_calc[0];
            end else begin
               sweeps_in = 2'd0;
               flip_in = 1'b0;
            end
         end
         sis_pkg::ST_FULL_RD: begin
            if (!full_more) begin
               pos_in = '0;
               sweeps_in = sweeps_ff - 2'd1;
               parity_in = !parity_ff ^ ((sweeps_ff == 2'd1) && flip_ff);
            end
         end
         sis_pkg::ST_FULL_WR: begin
            pos_in = pos_ff + POS_W'(1);
         end
         sis_pkg::ST_MUL_POS: begin
            acc_in = ACC_W'(mul_p);
         end
         sis_pkg::ST_MUL_LIM: begin
            lim_in = mul_p;
         end
         sis_pkg::ST_PART_RD: begin
            if (!part_more) begin
               if (!full_more) pos_in = '0;
               k_in = '0;
            end
         end
         sis_pkg::ST_PART_WR: begin
            pos_in = pos_ff + POS_W'(1);
            acc_in = acc_ff + ACC_W'(wl);
         end
         sis_pkg::ST_PROBE_CHK: begin
            cur_in = rd_cell;
            prod_p_in = 30'($signed({1'b0, p21}) * pw_ff);
            prod_c_in = 41'($signed({1'b0, rd_cell.count}) * fw_ff);
            if (key_match) begin
               wr_cell_in = hit_cell;
               wr_k_in = k_ff;
               res_in.hit = 1'b1;
               res_in.significant = hit_sig;
               res_in.replaced = 1'b0;
               res_in.cell_index = k_idx_ext[2:0];
            end
         end
         sis_pkg::ST_PROBE_CMP: begin
            if (k_ff == '0 || score < best_v_ff) begin
               best_v_in = score;
               best_k_in = k_ff;
               best_cell_in = cur_ff;
            end
            if (!last_k) k_in = k_ff + CELL_W'(1);
         end
         sis_pkg::ST_DECAY: begin
            wr_k_in = best_k_ff;
            wr_cell_in = dec_cell;
            res_in.hit = 1'b0;
            res_in.significant = 1'b0;
            res_in.replaced = 1'b0;
            res_in.cell_index = best_idx_ext[2:0];
            k_in = '0;
            mp_in = 20'(sis_pkg::TAIL_CAP);
            mc_in = 32'(sis_pkg::TAIL_CAP);
         end
         sis_pkg::ST_MIN_CHK: begin
            mp_in = mp_nx;
            mc_in = mc_nx;
            if (last_k) begin
               wr_cell_in = new_cell;
               res_in.replaced = 1'b1;
            end else begin
               k_in = k_ff + CELL_W'(1);
            end
         end
         sis_pkg::ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               last_time_in = req_ff.timestamp;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sis_pkg::ST_CLEAR;
         clr_ff <= '0;
         pos_ff <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sweeps_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pos_ff <= pos_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
         sweeps_ff <= sweeps_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      total_ff <= total_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
      lp_ff <= lp_in;
      tp_ff <= tp_in;
      phase_ff <= phase_in;
      bkt_ff <= bkt_in;
      parity_ff <= parity_in;
      flip_ff <= flip_in;
      acc_ff <= acc_in;
      lim_ff <= lim_in;
      base_ff <= base_in;
      k_ff <= k_in;
      cur_ff <= cur_in;
      prod_p_ff <= prod_p_in;
      prod_c_ff <= prod_c_in;
      best_v_ff <= best_v_in;
      best_k_ff <= best_k_in;
      best_cell_ff <= best_cell_in;
      mp_ff <= mp_in;
      mc_ff <= mc_in;
      wr_cell_ff <= wr_cell_in;
      wr_k_ff <= wr_k_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // pointer inside the swept range once the probe starts
   assert property (@(posedge clock) disable iff (reset)
      state_ff == sis_pkg::ST_PROBE_RD |-> pos_ff < total_ff)
      else $error("sweep pointer out of range at probe");

   // all period sweeps finished before the phase sweep
   assert property (@(posedge clock) disable iff (reset)
      state_ff == sis_pkg::ST_MUL_LIM |-> sweeps_ff == 2'd0)
      else $error("period sweeps left at phase sweep");

   // finishing a transaction presents its result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sis_pkg::ST_WRITE && out_free) |=>
         (rsp_valid_ff && state_ff == sis_pkg::ST_IDLE))
      else $error("result not presented");

endmodule

`default_nettype wire

### bench/tb_significant_item_sketch_top.sv
`timescale 1ns / 100ps

module tb_significant_item_sketch_top;

   localparam int NCELL = sis_pkg::BUCKETS * sis_pkg::CELLS;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 200;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   typedef struct {
      logic [63:0]      key;
      logic [11:0]      bucket;
      logic [31:0]      ts;
      bit               typed;
      sis_pkg::rsp_type want;
   } stim_row_type;

   typedef struct {
      logic [31:0]   win;
      logic [7:0]    pw;
      logic [7:0]    fw;
      logic [31:0]   fth;
      logic [19:0]   pth;
      logic          fod;
      logic [12:0]   nb;
      int            items;
      idle_kind_type mode;
      int            step;
      bit            jumps;
   } phase_cfg_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sis_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sis_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [sis_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sis_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   significant_item_sketch_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // sketch image
   logic [63:0] sk_key [NCELL];
   bit          sk_valid [NCELL];
   logic [19:0] sk_pers [NCELL];
   logic [31:0] sk_count [NCELL];
   bit          sk_odd [NCELL];
   bit          sk_even [NCELL];
   int unsigned sweep_pos;
   logic [31:0] prev_time;

   logic [31:0]       win_len = 1000;
   logic signed [7:0] pers_wt = 3;
   logic signed [7:0] freq_wt = 10;
   logic [31:0]       freq_thr = 100;
   logic [19:0]       pers_thr = 30;
   bit                freq_only = 1'b1;
   logic [12:0]       bkt_used = 4096;

   sis_pkg::rsp_type expected_rsps [$];
   int               fail_count = 0;
   int               cycle_count = 0;
   idle_kind_type    idle_mode = IDLE_NONE;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   function automatic void fold_flags(int unsigned i, bit par);
      if (par && sk_even[i]) begin
         if (sk_pers[i] != sis_pkg::PERS_MAX) sk_pers[i]++;
         sk_even[i] = 1'b0;
      end
      if (!par && sk_odd[i]) begin
         if (sk_pers[i] != sis_pkg::PERS_MAX) sk_pers[i]++;
         sk_odd[i] = 1'b0;
      end
   endfunction

   function automatic longint cell_rank(int unsigned i);
      longint p;
      longint c;
      p = sk_pers[i];
      p = p + sk_odd[i] + sk_even[i];
      c = sk_count[i];
      return p * longint'(pers_wt) + c * longint'(freq_wt);
   endfunction

   function automatic sis_pkg::rsp_type predict_response(sis_pkg::req_type it);
      longint unsigned w, tp, lp, periods, nsweep;
      int unsigned nb, total, phase, base, best, i, mp, mc;
      longint bestv, v, c;
      bit par;
      int hitk;
      sis_pkg::rsp_type r;
      r = '0;
      w = (win_len == 0) ? 64'd1 : 64'(win_len);
      nb = bkt_used;
      if (nb == 0) nb = 1;
      if (nb > sis_pkg::BUCKETS) nb = sis_pkg::BUCKETS;
      total = nb * sis_pkg::CELLS;
      if (sweep_pos >= total) sweep_pos = 0;
      tp = 64'(it.timestamp) / w;
      lp = 64'(prev_time) / w;
      par = lp[0];
      if (tp > lp) begin
         periods = tp - lp;
         nsweep = (periods < 3) ? periods : 3;
         for (longint unsigned s = 0; s < nsweep; s++) begin
            while (sweep_pos < total) begin
               fold_flags(sweep_pos, par);
               sweep_pos++;
            end
            sweep_pos = 0;
            par = ~par;
         end
         par = par ^ ((periods - nsweep) & 64'd1) != 0;
      end
      phase = 32'(64'(it.timestamp) % w);
      while (sweep_pos < total && (w * 64'(sweep_pos)) / 64'(total) <= 64'(phase)) begin
         fold_flags(sweep_pos, par);
         sweep_pos++;
      end
      if (sweep_pos >= total) sweep_pos = 0;

      base = it.bucket * sis_pkg::CELLS;
      hitk = -1;
      best = 0;
      bestv = 0;
      for (int k = 0; k < sis_pkg::CELLS; k++) begin
         i = base + k;
         if (sk_valid[i] && sk_key[i] == it.key) begin
            hitk = k;
            break;
         end
         v = cell_rank(i);
         if (k == 0 || v < bestv) begin
            best = k;
            bestv = v;
         end
      end

      if (hitk >= 0) begin
         i = base + hitk;
         if (par) sk_odd[i] = 1'b1;
         else sk_even[i] = 1'b1;
         if (sk_count[i] != 32'hFFFFFFFF) sk_count[i]++;
         r.hit = 1'b1;
         r.significant = sk_count[i] >= freq_thr && ({1'b0, sk_pers[i]} + 21'd1) >= pers_thr;
         r.cell_index = hitk[2:0];
      end else begin
         i = base + best;
         r.cell_index = best[2:0];
         if (!freq_only && sk_pers[i] > 0) sk_pers[i]--;
         if (sk_count[i] > 0) sk_count[i]--;
         c = sk_count[i];
         if (c * longint'(freq_wt) <= 0) begin
            mp = sis_pkg::TAIL_CAP;
            mc = sis_pkg::TAIL_CAP;
            for (int j = 0; j < sis_pkg::CELLS; j++) begin
               if (j != best) begin
                  if (sk_pers[base + j] < mp) mp = sk_pers[base + j];
                  if (sk_count[base + j] < mc) mc = sk_count[base + j];
               end
            end
            sk_key[i] = it.key;
            sk_valid[i] = 1'b1;
            sk_pers[i] = (mp > 0) ? 20'(mp - 1) : 20'd0;
            sk_count[i] = (mc > 2) ? mc - 1 : 32'd1;
            sk_odd[i] = par;
            sk_even[i] = ~par;
            r.replaced = 1'b1;
         end
      end
      prev_time = it.timestamp;
      return r;
   endfunction

   task automatic send_transaction(input sis_pkg::req_type it, input bit typed,
                                   input sis_pkg::rsp_type want);
      sis_pkg::rsp_type predicted;
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 28 : 0;
      while ($urandom_range(99) < pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      predicted = predict_response(it);
      expected_rsps.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_phase(input phase_cfg_type pc);
      write_reg(sis_pkg::REG_WINDOW_LENGTH, pc.win);
      write_reg(sis_pkg::REG_PERSIST_WEIGHT, {24'd0, pc.pw});
      write_reg(sis_pkg::REG_FREQ_WEIGHT, {24'd0, pc.fw});
      write_reg(sis_pkg::REG_FREQ_THRESHOLD, pc.fth);
      write_reg(sis_pkg::REG_PERSIST_THRESHOLD, {12'd0, pc.pth});
      write_reg(sis_pkg::REG_FREQ_ONLY_DECAY, {31'd0, pc.fod});
      write_reg(sis_pkg::REG_BUCKETS_IN_USE, {19'd0, pc.nb});
      @(negedge clock);
      csr_we <= 1'b0;
      win_len = pc.win;
      pers_wt = pc.pw;
      freq_wt = pc.fw;
      freq_thr = pc.fth;
      pers_thr = pc.pth;
      freq_only = pc.fod;
      bkt_used = pc.nb;
   endtask

   always @(negedge clock) begin
      int pct;
      pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 28 : 0;
      rsp_ready <= ($urandom_range(99) >= pct);
   end

   always @(posedge clock) begin
      sis_pkg::rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", rsp_data.hit, want.hit));
            if (rsp_data.significant !== want.significant)
               report_mismatch($sformatf("significant %b, expected %b",
                                         rsp_data.significant, want.significant));
            if (rsp_data.replaced !== want.replaced)
               report_mismatch($sformatf("replaced %b, expected %b",
                                         rsp_data.replaced, want.replaced));
            if (rsp_data.cell_index !== want.cell_index)
               report_mismatch($sformatf("cell_index %0d, expected %0d",
                                         rsp_data.cell_index, want.cell_index));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   stim_row_type directed [$] = '{
      '{64'd0, 12'd0, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b1, 3'd0}},
      '{64'd0, 12'd0, 32'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 3'd0}},
      '{64'hFFFFFFFFFFFFFFFF, 12'd0, 32'd1, 1'b1, '{1'b0, 1'b0, 1'b1, 3'd1}},
      '{64'hFFFFFFFFFFFFFFFF, 12'd4095, 32'd2, 1'b1, '{1'b0, 1'b0, 1'b1, 3'd0}},
      '{64'h5555555555555555, 12'hAAA, 32'd3, 1'b0, '0},
      '{64'hAAAAAAAAAAAAAAAA, 12'h555, 32'd20, 1'b0, '0},
      '{64'd0, 12'd0, 32'd5, 1'b1, '{1'b1, 1'b0, 1'b0, 3'd0}},
      '{64'd1, 12'd1, 32'd10, 1'b0, '0},
      '{64'd1, 12'd1, 32'd11, 1'b0, '0},
      '{64'd1, 12'd1, 32'd12, 1'b0, '0},
      '{64'd2, 12'd1, 32'd13, 1'b0, '0},
      '{64'd3, 12'd1, 32'd14, 1'b0, '0},
      '{64'd4, 12'd1, 32'd15, 1'b0, '0},
      '{64'd5, 12'd1, 32'd16, 1'b0, '0},
      '{64'd6, 12'd1, 32'd17, 1'b0, '0},
      '{64'd7, 12'd1, 32'd18, 1'b0, '0},
      '{64'd8, 12'd1, 32'd19, 1'b0, '0},
      '{64'd9, 12'd1, 32'd20, 1'b0, '0},
      '{64'd10, 12'd1, 32'd21, 1'b0, '0},
      '{64'd1, 12'd1, 32'd22, 1'b0, '0},
      '{64'd2, 12'd1, 32'd23, 1'b0, '0},
      '{64'h8000000000000001, 12'd2, 32'd30, 1'b0, '0}
   };

   phase_cfg_type phases [$] = '{
      '{32'd20, 8'sd3, 8'sd10, 32'd3, 20'd1, 1'b1, 13'd4, 300, IDLE_NONE, 7, 1'b1},
      '{32'd0, 8'h80, 8'h80, 32'd0, 20'd0, 1'b0, 13'd2, 250, IDLE_SENDER, 3, 1'b1},
      '{32'd50, 8'h7F, 8'h7F, 32'hFFFFFFFF, 20'hFFFFF, 1'b0, 13'd8, 250, IDLE_RECEIVER,
        20, 1'b1},
      '{32'd1, 8'd0, 8'd1, 32'd5, 20'd2, 1'b1, 13'd0, 200, IDLE_BOTH, 2, 1'b1},
      '{32'hFFFFFFFF, 8'd5, 8'd0, 32'd10, 20'd0, 1'b0, 13'd8191, 100, IDLE_BOTH, 3,
        1'b0},
      '{32'd30, 8'hFF, 8'hFF, 32'd2, 20'd2, 1'b0, 13'd3, 250, IDLE_SENDER, 10, 1'b1},
      '{32'd7, 8'sd3, 8'sd10, 32'd4, 20'd3, 1'b1, 13'd5, 150, IDLE_RECEIVER, 4, 1'b1}
   };

   initial begin
      logic [63:0] key_pool [12];
      logic [31:0] cur_ts;
      sis_pkg::req_type it;
      int nb_eff, sel;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[n])
         send_transaction('{directed[n].key, directed[n].bucket, directed[n].ts},
                          directed[n].typed, directed[n].want);
      drain_results();

      cur_ts = 32'd0;
      foreach (phases[p]) begin
         apply_phase(phases[p]);
         nb_eff = (phases[p].nb == 0) ? 1 :
                  (phases[p].nb > sis_pkg::BUCKETS) ? sis_pkg::BUCKETS : phases[p].nb;
         if (!phases[p].jumps) cur_ts = 32'd0;
         foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
         key_pool[0] = 64'd0;
         key_pool[1] = 64'hFFFFFFFFFFFFFFFF;
         for (int n = 0; n < phases[p].items; n++) begin
            idle_mode = (n % 100 < 25) ? IDLE_NONE : phases[p].mode;
            sel = $urandom_range(99);
            if (!phases[p].jumps || sel < 85) cur_ts = cur_ts + $urandom_range(phases[p].step);
            else if (sel < 92) cur_ts = cur_ts + $urandom;
            else if (sel < 96) cur_ts = cur_ts - $urandom_range(phases[p].step);
            else if (sel < 98) cur_ts = 32'hFFFFFFFF;
            else cur_ts = $urandom;
            it.timestamp = cur_ts;
            it.key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(11)];
            if (!phases[p].jumps) it.bucket = 12'($urandom_range(7));
            else if ($urandom_range(4) == 0) it.bucket = 12'($urandom_range(4095));
            else it.bucket = 12'($urandom_range(nb_eff - 1));
            send_transaction(it, 1'b0, '0);
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
design/sis_pkg.sv
design/sis_ram.sv
design/significant_item_sketch_top.sv
bench/tb_significant_item_sketch_top.sv
